// ----- hdl/eolf_pkg.sv -----
// ----------------------------------------------------------------------------
// eolf_pkg
// shared types, constants and fixed-point helpers for the exp-over-linear
// residual and jacobian unit
// ----------------------------------------------------------------------------
package eolf_pkg;

  localparam int unsigned DIV_STEPS = 49;
  localparam logic [62:0] SUM_MAX = '1;
  localparam logic signed [47:0] EXP_LIMIT = 48'sd1048576;
  localparam logic signed [31:0] LOG2E_Q16 = 32'sd94548;
  localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;

  // register indexes on the configuration channel
  localparam logic [1:0] REG_DECAY_RATE   = 2'd0;
  localparam logic [1:0] REG_DENOM_OFFSET = 2'd1;
  localparam logic [1:0] REG_DENOM_SLOPE  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_MUL_BX, OP_CALC_T, OP_CALC_L, OP_CALC_U, OP_CALC_E,
    OP_DS_MODEL, OP_WB_MODEL, OP_DS_RES, OP_WB_RES, OP_DS_G, OP_WB_G,
    OP_MUL_XG, OP_CALC_D0, OP_DS_D1, OP_WB_D1, OP_DS_D2, OP_WB_D2,
    OP_ACC, OP_ZERO, OP_OUT
  } op_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
  } cmd_t;

  typedef struct packed {
    logic in_valid;
    logic div_busy;
    logic zero_case;
    logic out_full;
  } stat_t;

  // 2^(j/16) in q16, j = 0..16
  function automatic logic [17:0] pow2_tab(input logic [4:0] j);
    logic [17:0] v;
    case (j)
      5'd0:    v = 18'd65536;
      5'd1:    v = 18'd68438;
      5'd2:    v = 18'd71468;
      5'd3:    v = 18'd74632;
      5'd4:    v = 18'd77936;
      5'd5:    v = 18'd81386;
      5'd6:    v = 18'd84990;
      5'd7:    v = 18'd88752;
      5'd8:    v = 18'd92682;
      5'd9:    v = 18'd96785;
      5'd10:   v = 18'd101070;
      5'd11:   v = 18'd105545;
      5'd12:   v = 18'd110218;
      5'd13:   v = 18'd115098;
      5'd14:   v = 18'd120194;
      5'd15:   v = 18'd125515;
      5'd16:   v = 18'd131072;
      default: v = 18'd131072;
    endcase
    return v;
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sh0000_0000_7fff_ffff) || (v < -64'sh0000_0000_8000_0000);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh0000_0000_7fff_ffff) r = 32'sh7fff_ffff;
    else if (v < -64'sh0000_0000_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // add half an lsb and floor-shift a q32.32 product back to q16.16
  function automatic logic signed [63:0] round16(input logic signed [63:0] p);
    return (p + 64'sd32768) >>> 16;
  endfunction

endpackage

// ----- hdl/eolf_in_if.sv -----
// ----------------------------------------------------------------------------
// eolf_in_if
// sample channel: x, y, sigma and the last-sample mark
// ----------------------------------------------------------------------------
interface eolf_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_value;
  logic signed [31:0] y_value;
  logic signed [31:0] sigma_value;
  logic               last_sample;

  modport src (output valid, x_value, y_value, sigma_value, last_sample, input ready);
  modport snk (input valid, x_value, y_value, sigma_value, last_sample, output ready);
endinterface

// ----- hdl/eolf_out_if.sv -----
// ----------------------------------------------------------------------------
// eolf_out_if
// result channel: residual, jacobian row, squared sum and flags
// ----------------------------------------------------------------------------
interface eolf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] residual;
  logic signed [31:0] deriv_rate;
  logic signed [31:0] deriv_offset;
  logic signed [31:0] deriv_slope;
  logic [62:0]        sum_squares;
  logic               sum_valid;
  logic               math_error;

  modport src (output valid, residual, deriv_rate, deriv_offset, deriv_slope,
               sum_squares, sum_valid, math_error, input ready);
  modport snk (input valid, residual, deriv_rate, deriv_offset, deriv_slope,
               sum_squares, sum_valid, math_error, output ready);
endinterface

// ----- hdl/eolf_cfg_if.sv -----
// ----------------------------------------------------------------------------
// eolf_cfg_if
// configuration write channel: register index and data
// ----------------------------------------------------------------------------
interface eolf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport src (output valid, index, data, input ready);
  modport snk (input valid, index, data, output ready);
endinterface

// ----- hdl/eolf_div.sv -----
// ----------------------------------------------------------------------------
// eolf_div
// radix-2 restoring divider, (num * 2^16) / den truncated toward zero
// ----------------------------------------------------------------------------
module eolf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [32:0] num,
  input  logic signed [31:0] den,
  output logic               busy,
  output logic signed [63:0] quot
);
  import eolf_pkg::*;

  logic [48:0] nq;
  logic [31:0] dmag;
  logic [31:0] rem;
  logic        neg;
  logic [5:0]  cnt;
  logic [32:0] num_abs;
  logic [32:0] r2;
  logic        fit;

  assign num_abs = num[32] ? 33'(-num) : 33'(num);
  assign r2      = {rem, nq[48]};
  assign fit     = r2 >= {1'b0, dmag};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'(DIV_STEPS - 1);
    end else if (busy) begin
      if (cnt == 6'd0) busy <= 1'b0;
      else cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nq   <= {num_abs, 16'd0};
      dmag <= den[31] ? 32'(-den) : 32'(den);
      rem  <= '0;
      neg  <= num[32] ^ den[31];
    end else if (busy) begin
      rem <= fit ? 32'(r2 - {1'b0, dmag}) : r2[31:0];
      nq  <= {nq[47:0], fit};
    end
  end

  assign quot = neg ? -$signed({15'd0, nq}) : $signed({15'd0, nq});
endmodule

// ----- hdl/eolf_datapath.sv -----
// ----------------------------------------------------------------------------
// eolf_datapath
// registers, shared multiplier, exp table and divider for one sample
// ----------------------------------------------------------------------------
module eolf_datapath (
  input  logic          clk,
  input  logic          rst,
  input  eolf_pkg::cmd_t cmd,
  output eolf_pkg::stat_t stat,
  eolf_in_if.snk        samples,
  eolf_out_if.src       results,
  eolf_cfg_if.snk       cfg
);
  import eolf_pkg::*;

  logic signed [31:0] b1, b2, b3;
  logic signed [31:0] x, y, sg;
  logic               last;
  logic signed [63:0] prod;
  logic signed [47:0] t;
  logic signed [31:0] e, l, model, res, g, d0, d1, d2;
  logic signed [7:0]  k;
  logic [3:0]         idx;
  logic               err;
  logic [62:0]        acc;
  logic [62:0]        acc_next;
  logic [62:0]        sum_cur;
  logic [62:0]        sum_hold;
  logic               sat_hit;

  logic               o_valid;
  logic signed [31:0] o_res, o_d0, o_d1, o_d2;
  logic [62:0]        o_sum;
  logic               o_last, o_err;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic               div_start;
  logic signed [32:0] div_num;
  logic signed [31:0] div_den;
  logic               div_busy;
  logic signed [63:0] div_quot;

  logic signed [63:0] t_full, l_sum, m, shl, shr, g_neg;
  logic signed [31:0] q_sat;
  logic [7:0]         neg_k;
  logic               big, tiny;
  logic [3:0]         fidx;
  logic [62:0]        headroom;

  eolf_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .busy(div_busy), .quot(div_quot)
  );

  assign fidx = prod[31:28];

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_MUL_BX: begin mul_a = b1; mul_b = x; end
      OP_CALC_T: begin mul_a = b3; mul_b = x; end
      OP_CALC_L: begin mul_a = t[31:0]; mul_b = LOG2E_Q16; end
      OP_CALC_U: begin
        mul_a = $signed({14'd0, pow2_tab({1'b0, fidx} + 5'd1)})
              - $signed({14'd0, pow2_tab({1'b0, fidx})});
        mul_b = $signed({20'd0, prod[27:16]});
      end
      OP_MUL_XG:  begin mul_a = x; mul_b = g; end
      OP_CALC_D0: begin mul_a = res; mul_b = res; end
      default: ;
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // divider operand selection
  always_comb begin
    div_start = 1'b1;
    div_num   = '0;
    div_den   = l;
    case (cmd.op)
      OP_DS_MODEL: div_num = 33'(e);
      OP_DS_RES: begin div_num = 33'(model) - 33'(y); div_den = sg; end
      OP_DS_G:   begin div_num = 33'(model); div_den = sg; end
      OP_DS_D1:  div_num = 33'(g);
      OP_DS_D2:  div_num = 33'(d0);
      default:   div_start = 1'b0;
    endcase
  end

  // exp range reduction and scaling
  assign t_full = -round16(prod);
  assign l_sum  = 64'(b2) + round16(prod);
  assign big    = t >= EXP_LIMIT;
  assign tiny   = t <= -EXP_LIMIT;
  assign m      = $signed({46'd0, pow2_tab({1'b0, idx})}) + (prod >>> 12);
  assign shl    = m << k[4:0];
  assign neg_k  = 8'(-k);
  assign shr    = (m + (64'sd1 << (neg_k[4:0] - 5'd1))) >>> neg_k[4:0];
  assign q_sat  = sat32(div_quot);
  assign g_neg  = -64'(q_sat);

  // saturating accumulate and last-sample handling
  assign headroom = SUM_MAX - acc;
  always_comb begin
    sum_cur = acc;
    sat_hit = 1'b0;
    if (cmd.op == OP_ACC) begin
      if (prod[63] || (prod[62:0] > headroom)) begin
        sum_cur = SUM_MAX;
        sat_hit = 1'b1;
      end else begin
        sum_cur = acc + prod[62:0];
      end
    end
    acc_next = last ? '0 : sum_cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1  <= 32'sd65536;
      b2  <= 32'sd65536;
      b3  <= '0;
      acc <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_DECAY_RATE:   b1 <= cfg.data;
          REG_DENOM_OFFSET: b2 <= cfg.data;
          REG_DENOM_SLOPE:  b3 <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ACC || cmd.op == OP_ZERO) acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        x    <= samples.x_value;
        y    <= samples.y_value;
        sg   <= samples.sigma_value;
        last <= samples.last_sample;
        err  <= 1'b0;
      end
      OP_MUL_BX: prod <= mul_p;
      OP_CALC_T: begin
        t    <= t_full[47:0];
        prod <= mul_p;
      end
      OP_CALC_L: begin
        l    <= sat32(l_sum);
        err  <= err | ovf32(l_sum);
        prod <= mul_p;
      end
      OP_CALC_U: begin
        k    <= prod[39:32];
        idx  <= fidx;
        prod <= mul_p;
      end
      OP_CALC_E: begin
        if (big) begin
          e   <= Q_MAX;
          err <= 1'b1;
        end else if (tiny) begin
          e <= '0;
        end else if (!k[7]) begin
          e   <= sat32(shl);
          err <= err | ovf32(shl);
        end else begin
          e <= shr[31:0];
        end
      end
      OP_WB_MODEL: begin model <= q_sat; err <= err | ovf32(div_quot); end
      OP_WB_RES:   begin res   <= q_sat; err <= err | ovf32(div_quot); end
      OP_WB_G: begin
        g   <= sat32(g_neg);
        err <= err | ovf32(div_quot) | ovf32(g_neg);
      end
      OP_MUL_XG: prod <= mul_p;
      OP_CALC_D0: begin
        d0   <= sat32(round16(prod));
        err  <= err | ovf32(round16(prod));
        prod <= mul_p;
      end
      OP_WB_D1: begin d1 <= q_sat; err <= err | ovf32(div_quot); end
      OP_WB_D2: begin d2 <= q_sat; err <= err | ovf32(div_quot); end
      OP_ACC: begin
        sum_hold <= last ? sum_cur : '0;
        err      <= err | sat_hit;
      end
      OP_ZERO: begin
        res      <= '0;
        d0       <= '0;
        d1       <= '0;
        d2       <= '0;
        err      <= 1'b1;
        sum_hold <= last ? sum_cur : '0;
      end
      OP_OUT: begin
        o_res  <= res;
        o_d0   <= d0;
        o_d1   <= d1;
        o_d2   <= d2;
        o_sum  <= sum_hold;
        o_last <= last;
        o_err  <= err;
      end
      default: ;
    endcase
  end

  // output register, freed by a transfer
  always_ff @(posedge clk) begin
    if (rst) o_valid <= 1'b0;
    else if (cmd.op == OP_OUT) o_valid <= 1'b1;
    else if (results.ready) o_valid <= 1'b0;
  end

  assign samples.ready        = cmd.in_ready;
  assign cfg.ready            = 1'b1;
  assign results.valid        = o_valid;
  assign results.residual     = o_res;
  assign results.deriv_rate   = o_d0;
  assign results.deriv_offset = o_d1;
  assign results.deriv_slope  = o_d2;
  assign results.sum_squares  = o_sum;
  assign results.sum_valid    = o_last;
  assign results.math_error   = o_err;

  assign stat.in_valid  = samples.valid;
  assign stat.div_busy  = div_busy;
  assign stat.zero_case = (l == 32'sd0) || (sg == 32'sd0);
  assign stat.out_full  = o_valid && !results.ready;
endmodule

// ----- hdl/eolf_ctrl.sv -----
// ----------------------------------------------------------------------------
// eolf_ctrl
// sequencer that steps the datapath through one sample
// ----------------------------------------------------------------------------
module eolf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  eolf_pkg::stat_t stat,
  output eolf_pkg::cmd_t  cmd
);
  import eolf_pkg::*;

  typedef enum logic [20:0] {
    S_IDLE = 21'd1 << 0,  S_MUL1 = 21'd1 << 1,  S_T    = 21'd1 << 2,
    S_L    = 21'd1 << 3,  S_U    = 21'd1 << 4,  S_E    = 21'd1 << 5,
    S_ZERO = 21'd1 << 6,  S_DS_M = 21'd1 << 7,  S_W_M  = 21'd1 << 8,
    S_DS_R = 21'd1 << 9,  S_W_R  = 21'd1 << 10, S_DS_G = 21'd1 << 11,
    S_W_G  = 21'd1 << 12, S_MG   = 21'd1 << 13, S_D0   = 21'd1 << 14,
    S_DS_1 = 21'd1 << 15, S_W_1  = 21'd1 << 16, S_DS_2 = 21'd1 << 17,
    S_W_2  = 21'd1 << 18, S_ACC  = 21'd1 << 19, S_DONE = 21'd1 << 20
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next   = state;
    cmd.op       = OP_NONE;
    cmd.in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (stat.in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_MUL1;
        end
      end
      S_MUL1: begin cmd.op = OP_MUL_BX; state_next = S_T; end
      S_T:    begin cmd.op = OP_CALC_T; state_next = S_L; end
      S_L:    begin cmd.op = OP_CALC_L; state_next = S_U; end
      S_U:    begin cmd.op = OP_CALC_U; state_next = S_E; end
      S_E: begin
        cmd.op     = OP_CALC_E;
        state_next = stat.zero_case ? S_ZERO : S_DS_M;
      end
      S_ZERO: begin cmd.op = OP_ZERO; state_next = S_DONE; end
      S_DS_M: begin cmd.op = OP_DS_MODEL; state_next = S_W_M; end
      S_W_M: begin
        if (!stat.div_busy) begin cmd.op = OP_WB_MODEL; state_next = S_DS_R; end
      end
      S_DS_R: begin cmd.op = OP_DS_RES; state_next = S_W_R; end
      S_W_R: begin
        if (!stat.div_busy) begin cmd.op = OP_WB_RES; state_next = S_DS_G; end
      end
      S_DS_G: begin cmd.op = OP_DS_G; state_next = S_W_G; end
      S_W_G: begin
        if (!stat.div_busy) begin cmd.op = OP_WB_G; state_next = S_MG; end
      end
      S_MG:   begin cmd.op = OP_MUL_XG; state_next = S_D0; end
      S_D0:   begin cmd.op = OP_CALC_D0; state_next = S_DS_1; end
      S_DS_1: begin cmd.op = OP_DS_D1; state_next = S_W_1; end
      S_W_1: begin
        if (!stat.div_busy) begin cmd.op = OP_WB_D1; state_next = S_DS_2; end
      end
      S_DS_2: begin cmd.op = OP_DS_D2; state_next = S_W_2; end
      S_W_2: begin
        if (!stat.div_busy) begin cmd.op = OP_WB_D2; state_next = S_ACC; end
      end
      S_ACC: begin cmd.op = OP_ACC; state_next = S_DONE; end
      S_DONE: begin
        if (!stat.out_full) begin cmd.op = OP_OUT; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ----- hdl/exp_over_linear_fit_residual_jacobian_unit.sv -----
// ----------------------------------------------------------------------------
// exp_over_linear_fit_residual_jacobian_unit
// weighted residual and jacobian row of exp(-b1*x)/(b2+b3*x), q16.16
// ----------------------------------------------------------------------------
// usage
//   samples: valid/ready channel with x_value, y_value, sigma_value and
//     last_sample; a transfer happens when valid and ready are both high
//   results: one result per sample with residual, the three jacobian
//     entries, the squared-residual sum (nonzero only on the last sample)
//     and sum_valid / math_error flags
//   cfg: write channel, index 0 decay_rate, 1 denom_offset, 2 denom_slope;
//     other indexes are dropped; always ready, write only while idle
// timing
//   one sample at a time; five divisions on the shared divider, at one
//   quotient bit per cycle, set the time from input transfer to result;
//   a zero denominator or sigma skips the divisions
//   the next sample is taken while a finished result still waits in the
//   output register; a stalled receiver holds the sequencer only at its
//   final step until the output register frees
// reset
//   synchronous rst restores b1 = 1.0, b2 = 1.0, b3 = 0, clears the sum and
//   drops any result in flight
// ----------------------------------------------------------------------------
module exp_over_linear_fit_residual_jacobian_unit (
  input  logic    clk,
  input  logic    rst,
  eolf_in_if.snk  samples,
  eolf_out_if.src results,
  eolf_cfg_if.snk cfg
);
  import eolf_pkg::*;

  // command and status between sequencer and datapath
  cmd_t  cmd;
  stat_t stat;

  // sequencer
  eolf_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .stat (stat),
    .cmd  (cmd)
  );

  // datapath with multiplier, exp table, divider and output register
  eolf_datapath u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .samples (samples),
    .results (results),
    .cfg     (cfg)
  );
endmodule

// ----- hdl/eolf_checker.sv -----
// ----------------------------------------------------------------------------
// eolf_checker
// port-level checks of the residual and jacobian unit
// ----------------------------------------------------------------------------
module eolf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        sum_valid,
  input logic [62:0] sum_squares
);
  // a result stays offered until transferred
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // one sample at a time: busy right after a transfer
  a_in_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  // the sum shows only on the last sample
  a_sum_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sum_valid |-> sum_squares == 63'd0)
    else $error("sum shown outside last sample");

  // reset leaves no result pending
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");
endmodule

bind exp_over_linear_fit_residual_jacobian_unit eolf_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .sum_valid   (results.sum_valid),
  .sum_squares (results.sum_squares)
);
